FILE: rtl/core/mnm_pkg.sv
// Shared constants, codes and control/status bundles for the MIDI note merger.
package mnm_pkg;

	// Default sizes
	localparam int NUM_KEYS_DEF     = 128;
	localparam int NUM_CHANNELS_DEF = 16;

	// Event opcodes
	localparam logic [1:0] OP_NOTE_ON  = 2'd0;
	localparam logic [1:0] OP_NOTE_OFF = 2'd1;
	localparam logic [1:0] OP_CTRL     = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [1:0] KIND_GROUP    = 2'd2;

	// Sustain pedal controller and its press threshold
	localparam logic [6:0] PEDAL_CC        = 7'd64;
	localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;

	// Base keys of the two group bitmaps
	localparam logic [6:0] GROUP_LO_BASE = 7'd0;
	localparam logic [6:0] GROUP_HI_BASE = 7'd64;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic sweep_start;
		logic sweep_rd;
		logic note_ex;
		logic pedal_set;
		logic pedal_clr;
		logic emit_lo;
		logic emit_hi;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic note_ok;
		logic pedal_press;
		logic pedal_release;
		logic sweep_last;
	} status_t;

endpackage

FILE: rtl/core/mnm_ctrl.sv
// Controller state machine: sequences note updates, pedal sweeps and group output.
module mnm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mnm_pkg::status_t  status,
	output mnm_pkg::cmd_t     cmd
);
	import mnm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_NOTE_EX = 6'b000010,
		ST_SWEEP   = 6'b000100,
		ST_DRAIN   = 6'b001000,
		ST_EMIT_LO = 6'b010000,
		ST_EMIT_HI = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	// Decode state into commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (status.note_ok) begin
						state_d = ST_NOTE_EX;
					end else if (status.pedal_press) begin
						cmd.pedal_set = 1'b1;
					end else if (status.pedal_release) begin
						cmd.pedal_clr   = 1'b1;
						cmd.sweep_start = 1'b1;
						state_d         = ST_SWEEP;
					end
				end
			end
			ST_NOTE_EX: begin
				cmd.note_ex = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT_LO;
			end
			ST_EMIT_LO: begin
				cmd.emit_lo = 1'b1;
				state_d     = ST_EMIT_HI;
			end
			ST_EMIT_HI: begin
				cmd.emit_hi = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_note_goes_exec: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && status.note_ok |=> state_q == ST_NOTE_EX)
		else $error("note beat did not enter execute state");

	a_sweep_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && !status.sweep_last |=> state_q == ST_SWEEP)
		else $error("sweep left early");

	a_emit_hi_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_HI |=> state_q == ST_IDLE)
		else $error("group output did not return to idle");

endmodule

FILE: rtl/core/mnm_dp.sv
// Datapath: key tables, pedal flags, sweep counter, group bitmaps and result registers.
module mnm_dp #(
	parameter int NUM_KEYS     = mnm_pkg::NUM_KEYS_DEF,
	parameter int NUM_CHANNELS = mnm_pkg::NUM_CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        opcode,
	input  logic [3:0]        channel,
	input  logic [6:0]        key,
	input  logic [6:0]        value,
	input  mnm_pkg::cmd_t     cmd,
	output mnm_pkg::status_t  status,
	output logic              strobe,
	output logic [1:0]        kind,
	output logic [6:0]        note,
	output logic [6:0]        velocity,
	output logic [63:0]       key_mask,
	output logic              last
);
	import mnm_pkg::*;

	localparam int KW = $clog2(NUM_KEYS);
	localparam int CW = NUM_CHANNELS;

	// Per-key tables and per-entry valid bits
	logic [CW-1:0]       hold_mem  [NUM_KEYS];
	logic [CW-1:0]       defer_mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] vld_q;

	logic [CW-1:0] pedal_q;
	logic [1:0]    op_q;
	logic [CW-1:0] chn_bit_q;
	logic [6:0]    key_q;
	logic [6:0]    val_q;
	logic [KW-1:0] cnt_q;
	logic [63:0]   lo_q, hi_q;

	logic [CW-1:0] hold_rd_s1, defer_rd_s1;
	logic          rvld_s1;
	logic          sw_s1_q;
	logic [KW-1:0] sw_key_s1;

	logic [KW-1:0] raddr, waddr;
	logic          we;
	logic [CW-1:0] h, d, h_n, d_n, off;
	logic          note_on, emit_note, set_bit;
	logic [6:0]    sw_key7;
	logic          chn_ok, key_ok, is_pedal;

	logic          strobe_q, last_q;
	logic [1:0]    kind_q;
	logic [6:0]    note_q, velocity_q;
	logic [63:0]   key_mask_q;

	function automatic logic [CW-1:0] chan_mask(input logic [3:0] c);
		logic [CW-1:0] m;
		for (int i = 0; i < CW; i++) begin
			m[i] = (c == 4'(i));
		end
		return m;
	endfunction

	// Classify the event on the ports
	assign chn_ok   = ({1'b0, channel} < 5'(NUM_CHANNELS));
	assign key_ok   = ({1'b0, key} < 8'(NUM_KEYS));
	assign is_pedal = chn_ok && (opcode == OP_CTRL) && (key == PEDAL_CC);

	assign status.note_ok       = chn_ok && key_ok &&
		((opcode == OP_NOTE_ON) || (opcode == OP_NOTE_OFF));
	assign status.pedal_press   = is_pedal && (value > PEDAL_THRESHOLD);
	assign status.pedal_release = is_pedal && (value <= PEDAL_THRESHOLD);
	assign status.sweep_last    = (cnt_q == KW'(NUM_KEYS - 1));

	// Capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode;
			chn_bit_q <= chan_mask(channel);
			key_q     <= key;
			val_q     <= value;
		end
	end

	// Update pedal flags and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedal_q <= '0;
			cnt_q   <= '0;
			sw_s1_q <= 1'b0;
		end else begin
			if (cmd.pedal_set) begin
				pedal_q <= pedal_q | chan_mask(channel);
			end else if (cmd.pedal_clr) begin
				pedal_q <= pedal_q & ~chan_mask(channel);
			end
			if (cmd.sweep_start) begin
				cnt_q <= '0;
			end else if (cmd.sweep_rd) begin
				cnt_q <= cnt_q + KW'(1);
			end
			sw_s1_q <= cmd.sweep_rd;
		end
	end

	// Read the tables, registered
	assign raddr = cmd.sweep_rd ? cnt_q : key[KW-1:0];

	always_ff @(posedge clk) begin
		hold_rd_s1  <= hold_mem[raddr];
		defer_rd_s1 <= defer_mem[raddr];
		rvld_s1     <= vld_q[raddr];
		sw_key_s1   <= cnt_q;
		if (we) begin
			hold_mem[waddr]  <= h_n;
			defer_mem[waddr] <= d_n;
		end
	end

	// Mark written entries valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	assign h = rvld_s1 ? hold_rd_s1 : '0;
	assign d = rvld_s1 ? defer_rd_s1 : '0;

	// Resolve a note event or one swept key
	always_comb begin
		h_n       = h;
		d_n       = d;
		note_on   = (op_q == OP_NOTE_ON) && (val_q != 7'd0);
		emit_note = 1'b0;
		set_bit   = 1'b0;
		off       = d & chn_bit_q;
		if (cmd.note_ex) begin
			if (note_on) begin
				h_n       = h | chn_bit_q;
				emit_note = 1'b1;
			end else if ((pedal_q & chn_bit_q) != '0) begin
				d_n = d | chn_bit_q;
			end else if ((h ^ chn_bit_q) != '0) begin
				h_n = h & ~chn_bit_q;
			end else begin
				h_n       = '0;
				emit_note = 1'b1;
			end
		end else if (sw_s1_q && (off != '0)) begin
			d_n = d & ~chn_bit_q;
			if ((h ^ off) != '0) begin
				h_n = h & ~off;
			end else begin
				h_n     = '0;
				set_bit = 1'b1;
			end
		end
	end

	assign we      = cmd.note_ex || sw_s1_q;
	assign waddr   = cmd.note_ex ? key_q[KW-1:0] : sw_key_s1;
	assign sw_key7 = 7'(sw_key_s1);

	// Collect released keys into the two bitmaps
	always_ff @(posedge clk) begin
		if (cmd.sweep_start) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (set_bit) begin
			if (sw_key7[6]) begin
				hi_q[sw_key7[5:0]] <= 1'b1;
			end else begin
				lo_q[sw_key7[5:0]] <= 1'b1;
			end
		end
	end

	// Drive the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_note || (cmd.emit_lo && (lo_q != '0)) ||
				(cmd.emit_hi && (hi_q != '0));
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (emit_note) begin
			kind_q     <= note_on ? KIND_NOTE_ON : KIND_NOTE_OFF;
			note_q     <= key_q;
			velocity_q <= note_on ? val_q : 7'd0;
			key_mask_q <= '0;
			last_q     <= 1'b1;
		end else if (cmd.emit_lo && (lo_q != '0)) begin
			kind_q     <= KIND_GROUP;
			note_q     <= GROUP_LO_BASE;
			velocity_q <= 7'd0;
			key_mask_q <= lo_q;
			last_q     <= (hi_q == '0);
		end else if (cmd.emit_hi && (hi_q != '0)) begin
			kind_q     <= KIND_GROUP;
			note_q     <= GROUP_HI_BASE;
			velocity_q <= 7'd0;
			key_mask_q <= hi_q;
			last_q     <= 1'b1;
		end
	end

	assign strobe   = strobe_q;
	assign kind     = kind_q;
	assign note     = note_q;
	assign velocity = velocity_q;
	assign key_mask = key_mask_q;
	assign last     = last_q;

	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (kind_q == KIND_GROUP) |-> key_mask_q != '0)
		else $error("empty group beat emitted");

	a_single_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (kind_q != KIND_GROUP) |-> key_mask_q == '0)
		else $error("single note beat carries a mask");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.note_ex && sw_s1_q))
		else $error("note update and sweep collide on the write port");

endmodule

FILE: rtl/core/midi_note_merge_with_sustain.sv
// Top level of the MIDI note merger with sustain pedal handling.
// Note event: busy in the execute state; the result strobe is registered from that state.
// Pedal release: sweeps every key table entry, then drains and emits, all while busy; group
// results strobe in the last cycle of busy and the cycle after. Others leave busy low.
// The key table read/modify/write port sets the sweep length; results are never stalled.
// Reset clears pedal flags, valid bits of both key tables and the state machine.
module midi_note_merge_with_sustain #(
	parameter int NUM_KEYS     = mnm_pkg::NUM_KEYS_DEF,
	parameter int NUM_CHANNELS = mnm_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [3:0]  channel,
	input  logic [6:0]  key,
	input  logic [6:0]  value,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [6:0]  note,
	output logic [6:0]  velocity,
	output logic [63:0] key_mask,
	output logic        last
);
	import mnm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequence the work
	mnm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	// Hold tables and build results
	mnm_dp #(
		.NUM_KEYS     (NUM_KEYS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.opcode   (opcode),
		.channel  (channel),
		.key      (key),
		.value    (value),
		.cmd      (cmd),
		.status   (status),
		.strobe   (strobe),
		.kind     (kind),
		.note     (note),
		.velocity (velocity),
		.key_mask (key_mask),
		.last     (last)
	);

endmodule

FILE: test/midi_note_merge_with_sustain_check.sv
// Checker for the MIDI note merger: tracks key and pedal state, predicts beats and compares.
module midi_note_merge_with_sustain_check #(
	parameter int NUM_KEYS     = mnm_pkg::NUM_KEYS_DEF,
	parameter int NUM_CHANNELS = mnm_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic [3:0]  channel,
	input  logic [6:0]  key,
	input  logic [6:0]  value,
	input  logic        strobe,
	input  logic [1:0]  kind,
	input  logic [6:0]  note,
	input  logic [6:0]  velocity,
	input  logic [63:0] key_mask,
	input  logic        last,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mnm_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  note;
		logic [6:0]  velocity;
		logic [63:0] key_mask;
		logic        last;
	} merged_beat_t;

	// Mirror of the key tables and pedal flags
	logic [15:0]  key_holders   [128];
	logic [15:0]  held_by_pedal [128];
	logic [15:0]  pedal_flags;
	merged_beat_t merged_q [$];

	task automatic queue_beat(input logic [1:0] k, input logic [6:0] n, input logic [6:0] vel,
			input logic [63:0] mask, input logic fin);
		merged_beat_t b;
		b.kind     = k;
		b.note     = n;
		b.velocity = vel;
		b.key_mask = mask;
		b.last     = fin;
		merged_q.push_back(b);
	endtask

	// Apply one accepted event to the mirror and queue the beats it causes
	task automatic merge_event(input logic [1:0] op, input logic [3:0] ch, input logic [6:0] k,
			input logic [6:0] v);
		logic [15:0] chan_bit;
		logic [15:0] freed;
		logic [63:0] lo_offs;
		logic [63:0] hi_offs;
		if (ch >= NUM_CHANNELS)
			return;
		chan_bit = 16'd1 << ch;
		if (op == OP_NOTE_ON || op == OP_NOTE_OFF) begin
			if (k >= NUM_KEYS)
				return;
			if (op == OP_NOTE_ON && v != 7'd0) begin
				key_holders[k] |= chan_bit;
				queue_beat(KIND_NOTE_ON, k, v, 64'd0, 1'b1);
			end else if ((pedal_flags & chan_bit) != 16'd0) begin
				held_by_pedal[k] |= chan_bit;
			end else if ((key_holders[k] ^ chan_bit) != 16'd0) begin
				key_holders[k] &= ~chan_bit;
			end else begin
				key_holders[k] = 16'd0;
				queue_beat(KIND_NOTE_OFF, k, 7'd0, 64'd0, 1'b1);
			end
		end else if (op == OP_CTRL && k == PEDAL_CC) begin
			if (v > PEDAL_THRESHOLD) begin
				pedal_flags |= chan_bit;
				return;
			end
			// Release: resolve every off this channel deferred
			pedal_flags &= ~chan_bit;
			lo_offs = 64'd0;
			hi_offs = 64'd0;
			for (int i = 0; i < NUM_KEYS; i++) begin
				freed = held_by_pedal[i] & chan_bit;
				if (freed != 16'd0) begin
					held_by_pedal[i] &= ~chan_bit;
					if ((key_holders[i] ^ freed) != 16'd0) begin
						key_holders[i] &= ~freed;
					end else begin
						key_holders[i] = 16'd0;
						if (i < 64)
							lo_offs[i] = 1'b1;
						else
							hi_offs[i - 64] = 1'b1;
					end
				end
			end
			if (lo_offs != 64'd0)
				queue_beat(KIND_GROUP, GROUP_LO_BASE, 7'd0, lo_offs, hi_offs == 64'd0);
			if (hi_offs != 64'd0)
				queue_beat(KIND_GROUP, GROUP_HI_BASE, 7'd0, hi_offs, 1'b1);
		end
	endtask

	// Compare each output beat, then take in the accepted event
	always @(posedge clk or negedge arst_n) begin
		merged_beat_t exp_beat;
		merged_beat_t got_beat;
		if (!arst_n) begin
			for (int i = 0; i < 128; i++) begin
				key_holders[i]   = 16'd0;
				held_by_pedal[i] = 16'd0;
			end
			pedal_flags = 16'd0;
			merged_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (strobe) begin
				got_beat = '{kind, note, velocity, key_mask, last};
				if (merged_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected beat: kind=%0d note=%0d vel=%0d mask=%h last=%0d",
							kind, note, velocity, key_mask, last);
				end else begin
					exp_beat = merged_q.pop_front();
					if (got_beat !== exp_beat) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch exp: kind=%0d note=%0d vel=%0d mask=%h last=%0d",
								exp_beat.kind, exp_beat.note, exp_beat.velocity,
								exp_beat.key_mask, exp_beat.last);
							$display("         got: kind=%0d note=%0d vel=%0d mask=%h last=%0d",
								kind, note, velocity, key_mask, last);
						end
					end
				end
			end
			if (start && !busy)
				merge_event(opcode, channel, key, value);
			pending = merged_q.size();
		end
	end

endmodule

FILE: test/midi_note_merge_with_sustain_test.sv
// Testbench top for the MIDI note merger: clock, reset, event stimulus and verdict.
module midi_note_merge_with_sustain_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mnm_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         EVENT_COUNT = 525;
	localparam int         CYCLE_LIMIT = 600_000;
	localparam int         DRAIN_WAIT  = NUM_KEYS_DEF + 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  opcode = OP_NOTE_ON;
	logic [3:0]  channel = 4'd0;
	logic [6:0]  key = 7'd0;
	logic [6:0]  value = 7'd0;
	logic        strobe;
	logic [1:0]  kind;
	logic [6:0]  note;
	logic [6:0]  velocity;
	logic [63:0] key_mask;
	logic        last;
	int          errors;
	int          pending;
	int          idle_pct = 0;
	int          cycles = 0;

	midi_note_merge_with_sustain u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .channel(channel), .key(key), .value(value),
		.strobe(strobe), .kind(kind), .note(note), .velocity(velocity),
		.key_mask(key_mask), .last(last)
	);

	midi_note_merge_with_sustain_check u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .channel(channel), .key(key), .value(value),
		.strobe(strobe), .kind(kind), .note(note), .velocity(velocity),
		.key_mask(key_mask), .last(last), .errors(errors), .pending(pending)
	);

	always #4 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Drive one event beat, idling first at random, and hold it until accepted
	task automatic send_event(input logic [1:0] op, input logic [3:0] ch, input logic [6:0] k,
			input logic [6:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		opcode  <= op;
		channel <= ch;
		key     <= k;
		value   <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Favor a few keys on both halves so holders and pedal offs collide
	function automatic logic [6:0] pick_key();
		case ($urandom_range(0, 15))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd63;
			3: return 7'd64;
			4: return 7'd65;
			5: return 7'd100;
			6: return 7'd126;
			7: return 7'd127;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic logic [3:0] pick_channel();
		if ($urandom_range(0, 9) < 7)
			return 4'($urandom_range(0, 3));
		return 4'($urandom_range(0, 15));
	endfunction

	initial begin : stimulus
		int          sel;
		int          counted;
		logic [1:0]  op;
		logic [3:0]  ch;
		logic [6:0]  k;
		logic [6:0]  v;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, sole and shared holders, pedal hold and release
		send_event(OP_NOTE_ON,  4'd0,  7'd0,   7'd127);
		send_event(OP_NOTE_ON,  4'd15, 7'd127, 7'd1);
		send_event(OP_NOTE_OFF, 4'd0,  7'd0,   7'd0);
		send_event(OP_NOTE_OFF, 4'd15, 7'd127, 7'd127);
		send_event(OP_NOTE_ON,  4'd1,  7'd60,  7'd64);
		send_event(OP_NOTE_ON,  4'd2,  7'd60,  7'd100);
		send_event(OP_NOTE_OFF, 4'd1,  7'd60,  7'd33);
		send_event(OP_NOTE_ON,  4'd2,  7'd60,  7'd0);
		send_event(OP_NOTE_OFF, 4'd3,  7'd5,   7'd10);
		send_event(OP_CTRL,     4'd4,  PEDAL_CC, 7'd65);
		send_event(OP_NOTE_ON,  4'd4,  7'd10,  7'd90);
		send_event(OP_NOTE_ON,  4'd4,  7'd100, 7'd91);
		send_event(OP_NOTE_OFF, 4'd4,  7'd10,  7'd0);
		send_event(OP_NOTE_ON,  4'd4,  7'd100, 7'd0);
		send_event(OP_NOTE_OFF, 4'd4,  7'd20,  7'd0);
		send_event(OP_CTRL,     4'd4,  PEDAL_CC, PEDAL_THRESHOLD);
		send_event(OP_CTRL,     4'd4,  PEDAL_CC, 7'd0);
		send_event(OP_CTRL,     4'd15, 7'd7,   7'd127);
		send_event(OP_UNUSED,   4'd9,  7'd127, 7'd127);
		send_event(OP_CTRL,     4'd5,  PEDAL_CC, 7'd127);
		send_event(OP_NOTE_ON,  4'd5,  7'd3,   7'd50);
		send_event(OP_NOTE_ON,  4'd6,  7'd3,   7'd51);
		send_event(OP_NOTE_OFF, 4'd5,  7'd3,   7'd0);
		send_event(OP_CTRL,     4'd5,  PEDAL_CC, 7'd0);
		send_event(OP_NOTE_OFF, 4'd6,  7'd3,   7'd0);

		// Random: mostly note and pedal traffic, some noise
		counted = 0;
		while (counted < EVENT_COUNT) begin
			idle_pct = (counted < EVENT_COUNT / 3) ? 23 :
				(counted < 2 * EVENT_COUNT / 3) ? 62 : 0;
			sel = $urandom_range(0, 99);
			ch  = pick_channel();
			k   = pick_key();
			v   = 7'($urandom_range(0, 127));
			if (sel < 40) begin
				op = OP_NOTE_ON;
				v  = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
			end else if (sel < 75) begin
				op = OP_NOTE_OFF;
			end else if (sel < 85) begin
				op = OP_CTRL;
				k  = PEDAL_CC;
				v  = 7'($urandom_range(65, 127));
			end else if (sel < 93) begin
				op = OP_CTRL;
				k  = PEDAL_CC;
				v  = 7'($urandom_range(0, 64));
			end else if (sel < 97) begin
				op = OP_CTRL;
				k  = 7'($urandom_range(0, 126));
				if (k >= PEDAL_CC)
					k = k + 7'd1;
			end else begin
				op = OP_UNUSED;
			end
			send_event(op, ch, k, v);
			counted++;
		end

		@(negedge clk);
		start <= 1'b0;

		// Drain outstanding beats, then let a full sweep pass
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
